// ===== rtl/spk_pkg.sv =====
// ----------------------------------------------------------------------------
// spk_pkg
// Types, constants and the round function shared by the 128-bit-block Speck
// encryption core and its key schedule.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int WORD_W     = 64;
    localparam int MAX_ROUNDS = 34;
    localparam int RK_AW      = $clog2(MAX_ROUNDS);
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 2;
    localparam int BASE_ROUNDS = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd4;

    // key length codes; the unused code behaves as the 256-bit key
    localparam logic [LEN_W-1:0] KEY_128 = 2'd0;
    localparam logic [LEN_W-1:0] KEY_192 = 2'd1;
    localparam logic [LEN_W-1:0] KEY_256 = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] plain_x;
        logic [WORD_W-1:0] plain_y;
    } spk_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_x;
        logic [WORD_W-1:0] cipher_y;
    } spk_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } spk_pair_t;

    // key schedule to core: status and round key write request
    typedef struct packed {
        logic              busy;
        logic [RK_AW-1:0]  rounds;
        logic              wr_en;
        logic [RK_AW-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } spk_ks_t;

    function automatic spk_pair_t spk_round(input logic [WORD_W-1:0] x,
                                            input logic [WORD_W-1:0] y,
                                            input logic [WORD_W-1:0] k);
        spk_pair_t r;
        r.x = ({x[7:0], x[WORD_W-1:8]} + y) ^ k;
        r.y = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ r.x;
        return r;
    endfunction

endpackage

// ===== rtl/speck128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// speck128_block_encrypt
// Speck encryption, 128-bit block, 128/192/256-bit key. Round keys sit in a
// synchronous memory and are read one round ahead of the round datapath.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_stall       spk_in_t  (plain_x, plain_y)
//  out       output     out_valid / out_stall     spk_out_t (cipher_x, cipher_y)
//  cfg       input      cfg_write                 cfg_index, cfg_data
//
//  A block passes through the single round unit, fed by the round key memory,
//  for 32, 33 or 34 rounds, then moves through the drain state to the output
//  register; the next request is taken only after its result has moved to
//  the output register.
//  A key write stalls the input through the write, a restart step and one
//  memory write per round; after reset the stall has only the restart and the writes.
//  A stalled output holds; a finished block waits in drain until it is free.
module speck128_block_encrypt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  spk_pkg::spk_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output spk_pkg::spk_out_t                out_data,
    input  logic                             cfg_write,
    input  logic [spk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spk_pkg::WORD_W-1:0]       cfg_data
);
    import spk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [RK_AW-1:0]  round_reg, round_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic              out_valid_reg, out_valid_next;
    spk_out_t          out_data_reg, out_data_next;
    logic              rd_en;
    logic [RK_AW-1:0]  rd_addr;
    logic [WORD_W-1:0] rk_q;
    logic [WORD_W-1:0] rk_mem [MAX_ROUNDS];
    logic              accept;
    logic              out_free;
    spk_ks_t           ks;
    spk_pair_t         rnd;

    spk_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ks        (ks)
    );

    // round key memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (ks.wr_en)
            rk_mem[ks.wr_addr] <= ks.wr_data;
        if (rd_en)
            rk_q <= rk_mem[rd_addr];
    end

    assign in_stall = (state_reg != ST_IDLE) || ks.busy || cfg_write;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rnd      = spk_round(x_reg, y_reg, rk_q);

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = round_reg + RK_AW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next     = in_data.plain_x;
                    y_next     = in_data.plain_y;
                    round_next = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                // rk_q holds the key of round_reg; fetch the next one
                x_next = rnd.x;
                y_next = rnd.y;
                if (round_reg == ks.rounds - RK_AW'(1))
                    state_next = ST_DRAIN;
                else
                begin
                    rd_en      = 1'b1;
                    round_next = round_reg + RK_AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.cipher_x = x_reg;
                    out_data_next.cipher_y = y_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/spk_expand.sv =====
// ----------------------------------------------------------------------------
// spk_expand
// Key registers and key schedule sequencer. Expands the key into the round
// key memory one round key per cycle after reset and after each key write.
// ----------------------------------------------------------------------------
module spk_expand (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [spk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spk_pkg::WORD_W-1:0]       cfg_data,
    output spk_pkg::spk_ks_t                 ks
);
    import spk_pkg::*;

    logic [LEN_W-1:0]  key_length_reg;
    logic [WORD_W-1:0] key_word_reg [4];
    logic              restart_reg, restart_next;
    logic              running_reg, running_next;
    logic [RK_AW-1:0]  i_reg, i_next;
    logic [1:0]        j_reg, j_next;
    logic [1:0]        last_j_reg, last_j_next;
    logic [RK_AW-1:0]  rounds_reg, rounds_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] l_reg [3];
    logic [WORD_W-1:0] l_next [3];
    logic              cfg_hit;
    spk_pair_t         step;

    assign cfg_hit = cfg_write && (cfg_index <= REG_KEY_WORD3);
    assign step    = spk_round(l_reg[j_reg], a_reg, WORD_W'(i_reg));

    always_comb
    begin
        restart_next = cfg_hit;
        running_next = running_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        last_j_next  = last_j_reg;
        rounds_next  = rounds_reg;
        a_next       = a_reg;
        l_next       = l_reg;
        if (restart_reg)
        begin
            running_next = 1'b1;
            i_next       = '0;
            j_next       = '0;
            case (key_length_reg)
                KEY_128:
                begin
                    a_next      = key_word_reg[1];
                    l_next[0]   = key_word_reg[0];
                    last_j_next = 2'd0;
                    rounds_next = RK_AW'(BASE_ROUNDS);
                end
                KEY_192:
                begin
                    a_next      = key_word_reg[2];
                    l_next[0]   = key_word_reg[1];
                    l_next[1]   = key_word_reg[0];
                    last_j_next = 2'd1;
                    rounds_next = RK_AW'(BASE_ROUNDS + 1);
                end
                default:
                begin
                    a_next      = key_word_reg[3];
                    l_next[0]   = key_word_reg[2];
                    l_next[1]   = key_word_reg[1];
                    l_next[2]   = key_word_reg[0];
                    last_j_next = 2'd2;
                    rounds_next = RK_AW'(BASE_ROUNDS + 2);
                end
            endcase
        end
        else if (running_reg)
        begin
            l_next[j_reg] = step.x;
            a_next        = step.y;
            i_next        = i_reg + RK_AW'(1);
            j_next        = (j_reg == last_j_reg) ? 2'd0 : j_reg + 2'd1;
            if (i_reg == rounds_reg - RK_AW'(1))
                running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_128;
            key_word_reg   <= '{default: '0};
            restart_reg    <= 1'b1;     // expand the all-zero key after reset
            running_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            last_j_reg     <= '0;
            rounds_reg     <= RK_AW'(BASE_ROUNDS);
        end
        else
        begin
            restart_reg <= restart_next;
            running_reg <= running_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            last_j_reg  <= last_j_next;
            rounds_reg  <= rounds_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KEY_LENGTH: key_length_reg  <= cfg_data[LEN_W-1:0];
                    REG_KEY_WORD0:  key_word_reg[0] <= cfg_data;
                    REG_KEY_WORD1:  key_word_reg[1] <= cfg_data;
                    REG_KEY_WORD2:  key_word_reg[2] <= cfg_data;
                    REG_KEY_WORD3:  key_word_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        l_reg <= l_next;
    end

    assign ks.busy    = restart_reg || running_reg;
    assign ks.rounds  = rounds_reg;
    assign ks.wr_en   = running_reg && !restart_reg;
    assign ks.wr_addr = i_reg;
    assign ks.wr_data = a_reg;

endmodule

// ===== rtl/spk_checker.sv =====
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks on the Speck encryption block, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  spk_pkg::spk_in_t                 in_data,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  spk_pkg::spk_out_t                out_data,
    input  logic                             cfg_write,
    input  logic [spk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spk_pkg::WORD_W-1:0]       cfg_data
);
    import spk_pkg::*;

    logic in_taken;
    assign in_taken = in_valid && !in_stall;

    // one block at a time: after a request the input stalls
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_taken |=> in_stall)
        else $error("request accepted while a block is in flight");

    // a key write restarts the schedule, which stalls the input
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index <= REG_KEY_WORD3) |-> in_stall ##1 in_stall)
        else $error("input not stalled around a key write");

    // a result shows up only after a request was worked on
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a block in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind speck128_block_encrypt spk_checker u_spk_checker (.*);

// ===== bench/tb_speck128_block_encrypt.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speck128_block_encrypt
// Self-checking bench for the Speck 128-bit block encryption core. A local
// cipher and key schedule predict each ciphertext. Plaintext requests are
// driven with random gaps and output stalls, under a series of key settings:
// the reset key, known answers, extreme keys, every key length code, unused
// register indexes, then random keys with random blocks.
// ----------------------------------------------------------------------------
module tb_speck128_block_encrypt;

    import spk_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int RESET_CYC  = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int END_PAUSE  = 40;
    localparam int PHASES     = 20;
    localparam int PHASE_LEN  = 40;

    // key length code with no meaning of its own, runs as the 256-bit key
    localparam logic [LEN_W-1:0] KEY_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    spk_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    spk_out_t             out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    // local copy of key settings and expanded schedule
    logic [LEN_W-1:0]  key_len_q;
    logic [WORD_W-1:0] key_words [4];
    logic [WORD_W-1:0] sched_keys [MAX_ROUNDS];
    int                sched_rounds;

    spk_out_t          expected_ciphers [$];
    spk_out_t          want;
    int                errors = 0;
    int                idle_cycles = 0;
    bit                steady_flow;

    logic [LEN_W-1:0]  len_codes [4] = '{KEY_128, KEY_192, KEY_256, KEY_UNUSED};

    speck128_block_encrypt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // one cipher round: x = (ror8(x) + y) ^ k, y = rol3(y) ^ x
    function automatic logic [2*WORD_W-1:0] mix_round(input logic [WORD_W-1:0] x,
                                                      input logic [WORD_W-1:0] y,
                                                      input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] nx;
        nx = ({x[7:0], x[WORD_W-1:8]} + y) ^ k;
        return {nx, {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ nx};
    endfunction

    function automatic void expand_schedule();
        int                extra;
        int                nl;
        int                j;
        logic [WORD_W-1:0] l [3];
        logic [WORD_W-1:0] a;
        extra = (key_len_q == KEY_128) ? 0 : (key_len_q == KEY_192) ? 1 : 2;
        nl = extra + 1;
        sched_rounds = BASE_ROUNDS + extra;
        if (sched_rounds > MAX_ROUNDS)
            sched_rounds = MAX_ROUNDS;
        a = key_words[nl];
        for (int i = 0; i < nl; i++)
            l[i] = key_words[nl - 1 - i];
        j = 0;
        for (int i = 0; i < sched_rounds; i++)
        begin
            sched_keys[i] = a;
            {l[j], a} = mix_round(l[j], a, 64'(i));
            j = (j + 1 >= nl) ? 0 : j + 1;
        end
    endfunction

    function automatic spk_out_t encrypt_block(input spk_in_t blk);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        spk_out_t          r;
        x = blk.plain_x;
        y = blk.plain_y;
        for (int i = 0; i < sched_rounds; i++)
            {x, y} = mix_round(x, y, sched_keys[i]);
        r.cipher_x = x;
        r.cipher_y = y;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(WORD_W-1){1'b0}}};
            3:       return {{(WORD_W-1){1'b0}}, 1'b1};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_KEY_LENGTH)
            key_len_q = data[LEN_W-1:0];
        else if (idx <= REG_KEY_WORD3)
            key_words[idx - 1] = data;
        if (idx <= REG_KEY_WORD3)
            expand_schedule();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_key(input logic [LEN_W-1:0] len,
                            input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                            input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
        logic [WORD_W-1:0] len_word;
        // upper bits of the length register are noise
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        write_reg(REG_KEY_LENGTH, len_word);
        write_reg(REG_KEY_WORD0, w0);
        write_reg(REG_KEY_WORD1, w1);
        write_reg(REG_KEY_WORD2, w2);
        write_reg(REG_KEY_WORD3, w3);
    endtask

    task automatic send_block(input logic [WORD_W-1:0] px, input logic [WORD_W-1:0] py);
        int      gap;
        spk_in_t blk;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        blk.plain_x = px;
        blk.plain_y = py;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= blk;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_ciphers.push_back(encrypt_block(blk));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_ciphers.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_key();
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        drain_results();
    endtask

    // published vectors; words above the selected length carry noise
    task automatic test_known_answers();
        load_key(KEY_128, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100,
                 {$urandom, $urandom}, {$urandom, $urandom});
        send_block(64'h6c61766975716520, 64'h7469206564616d20);
        drain_results();
        load_key(KEY_192, 64'h1716151413121110, 64'h0f0e0d0c0b0a0908,
                 64'h0706050403020100, {$urandom, $urandom});
        send_block(64'h7261482066656968, 64'h20646e6576612020);
        drain_results();
        load_key(KEY_256, 64'h1f1e1d1c1b1a1918, 64'h1716151413121110,
                 64'h0f0e0d0c0b0a0908, 64'h0706050403020100);
        send_block(64'h65736f6874206e49, 64'h202e72656e6f6f70);
        drain_results();
    endtask

    task automatic test_key_extremes();
        logic [WORD_W-1:0] k;
        for (int c = 0; c < 4; c++)
        begin
            for (int e = 0; e < 2; e++)
            begin
                k = e ? '1 : '0;
                load_key(len_codes[c], k, k, k, k);
                send_block('0, '0);
                send_block('1, '1);
                drain_results();
            end
        end
    endtask

    // writes past the last register must leave the schedule alone
    task automatic test_unused_index();
        load_key(KEY_192, rand_word(), rand_word(), rand_word(), rand_word());
        for (int k = 1; k <= 3; k++)
            write_reg(REG_KEY_WORD3 + CFG_IDX_W'(k), {$urandom, $urandom});
        send_block(rand_word(), rand_word());
        send_block(rand_word(), rand_word());
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++)
        begin
            load_key(len_codes[$urandom_range(0, 3)],
                     rand_word(), rand_word(), rand_word(), rand_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_KEY_WORD3 + CFG_IDX_W'($urandom_range(1, 3)),
                          {$urandom, $urandom});
            steady_flow = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_LEN; i++)
                send_block(rand_word(), rand_word());
            drain_results();
            steady_flow = 1'b0;
        end
    endtask

    // output side: random stall before each result
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = steady_flow ? 0 : $urandom_range(0, 4);
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_ciphers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h %h",
                         $time, out_data.cipher_x, out_data.cipher_y);
                errors++;
            end
            else
            begin
                want = expected_ciphers.pop_front();
                if (out_data.cipher_x !== want.cipher_x)
                begin
                    $display("%0t: cipher_x mismatch, expected %h, actual %h",
                             $time, want.cipher_x, out_data.cipher_x);
                    errors++;
                end
                if (out_data.cipher_y !== want.cipher_y)
                begin
                    $display("%0t: cipher_y mismatch, expected %h, actual %h",
                             $time, want.cipher_y, out_data.cipher_y);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("speck128_block_encrypt regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        steady_flow = 1'b0;
        key_len_q   = KEY_128;
        for (int i = 0; i < 4; i++)
            key_words[i] = '0;
        expand_schedule();
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_key();
        test_known_answers();
        test_key_extremes();
        test_unused_index();
        test_random_phases();

        drain_results();
        repeat (END_PAUSE) @(posedge clk);
        if (errors == 0)
            $display("speck128_block_encrypt regression: pass");
        else
            $display("speck128_block_encrypt regression: fail");
        $finish;
    end

endmodule
